// File: src/merge_sort_buffer_core_defines.svh
// Assertion macros for the merge sort buffer core.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef MERGE_SORT_BUFFER_CORE_DEFINES_SVH
`define MERGE_SORT_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MSB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MSB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/msb_pkg.sv
// Shared types for the merge sort buffer core.
// No dependencies; imported by the top level.
`default_nettype none

package msb_pkg;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PASS,
    S_RUN,
    S_HA,
    S_HB,
    S_MERGE,
    S_WA,
    S_WB,
    S_ERD,
    S_ECAP
  } msb_state_e;

endpackage

`default_nettype wire

// File: src/msb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module msb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/merge_sort_buffer_core.sv
// Merge sort buffer: collects signed 32-bit items, sorts them, streams them out.
// Depends on msb_pkg, msb_ram and merge_sort_buffer_core_defines.svh.
//
// Input channel (in_valid_i / in_stall_o, value_i, last_i): one item per cycle
// while loading. Up to MAX_ITEMS items are kept; items beyond that are dropped
// and the set is flagged. An item with last_i high closes the set.
// Output channel (out_valid_o / out_stall_i): one item per stored element in
// ascending order, end_of_run_o on the last, overflow_o on all if any dropped.
// Equal values keep the right run first, which is invisible for plain values.
// Sorting takes ceil(log2 n) merge passes. Each merged element is written in
// S_MERGE and the next head refetched in S_WA or S_WB, as one read port feeds
// both run heads; each result is read in S_ERD and captured in S_ECAP.
// The input stalls from the closing item until the last result is captured;
// the next set may load while that final result still waits.
// Reset clears the fill count, the drop flag and the output valid; memory
// contents are never cleared, only written entries are read.
// A stalled output holds its item; the sorter holds the next read until the
// output register frees.
`default_nettype none
`include "merge_sort_buffer_core_defines.svh"

module merge_sort_buffer_core import msb_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] value_i,
  input  wire logic               last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      sorted_value_o,
  output logic                    end_of_run_o,
  output logic                    overflow_o
);

  localparam int AW = $clog2(MAX_ITEMS);
  // Index width: holds the count plus run bounds that overshoot it.
  localparam int IW = $clog2(MAX_ITEMS + 1) + 1;
  localparam logic [IW-1:0] MaxCount = IW'(MAX_ITEMS);
  localparam logic [IW-1:0] IdxOne = IW'(1);

  msb_state_e state_q, state_d;

  logic [IW-1:0] count_q, count_d;
  logic          drop_q, drop_d;
  logic [IW-1:0] width_q, width_d;
  logic [IW-1:0] lo_q, lo_d;
  logic [IW-1:0] mid_q, mid_d;
  logic [IW-1:0] hi_q, hi_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] j_q, j_d;
  logic [IW-1:0] k_q, k_d;
  // Low: element memory is the source of the current pass.
  logic          src_sel_q, src_sel_d;

  logic signed [31:0] head_a_q, head_a_d;
  logic signed [31:0] head_b_q, head_b_d;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_value_q, out_value_d;
  logic               out_end_q, out_end_d;
  logic               out_ovf_q, out_ovf_d;

  // Memory ports.
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          elem_we;
  logic          scr_we;
  logic [31:0]   elem_rdata;
  logic [31:0]   scr_rdata;
  logic [31:0]   rd_data;

  // Merge helpers.
  logic [IW-1:0] lo_plus_w;
  logic [IW-1:0] lo_plus_2w;
  logic [IW-1:0] i_nx;
  logic [IW-1:0] j_nx;
  logic [IW-1:0] k_nx;
  logic          a_ok;
  logic          b_ok;
  logic          take_a;
  logic          last_emit;

  msb_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (elem_rdata)
  );

  msb_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_scr_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (scr_rdata)
  );

  assign rd_data    = src_sel_q ? scr_rdata : elem_rdata;
  assign lo_plus_w  = lo_q + width_q;
  assign lo_plus_2w = lo_q + (width_q << 1);
  assign i_nx       = i_q + IdxOne;
  assign j_nx       = j_q + IdxOne;
  assign k_nx       = k_q + IdxOne;
  assign a_ok       = (i_q < mid_q);
  assign b_ok       = (j_q < hi_q);
  // Take the left head only when strictly smaller; ties go right.
  assign take_a     = a_ok && (!b_ok || (head_a_q < head_b_q));
  assign last_emit  = (k_nx == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      drop_q      <= 1'b0;
      width_q     <= '0;
      lo_q        <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      src_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      width_q     <= width_d;
      lo_q        <= lo_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      src_sel_q   <= src_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    head_a_q    <= head_a_d;
    head_b_q    <= head_b_d;
    out_value_q <= out_value_d;
    out_end_q   <= out_end_d;
    out_ovf_q   <= out_ovf_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    width_d     = width_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    src_sel_d   = src_sel_q;
    head_a_d    = head_a_q;
    head_b_d    = head_b_q;
    out_value_d = out_value_q;
    out_end_d   = out_end_q;
    out_ovf_d   = out_ovf_q;
    in_stall_o  = (state_q != S_LOAD);
    rd_addr     = '0;
    wr_addr     = '0;
    wr_data     = value_i;
    elem_we     = 1'b0;
    scr_we      = 1'b0;

    // Drop the output item once the receiver takes it.
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (count_q < MaxCount) begin
            elem_we = 1'b1;
            wr_addr = count_q[AW-1:0];
            count_d = count_q + IdxOne;
          end else begin
            drop_d = 1'b1;
          end
          if (last_i) begin
            width_d   = IdxOne;
            src_sel_d = 1'b0;
            state_d   = S_PASS;
          end
        end
      end

      S_PASS: begin
        // Sorted once a single run spans the whole set.
        if (width_q >= count_q) begin
          k_d     = '0;
          state_d = S_ERD;
        end else begin
          lo_d    = '0;
          state_d = S_RUN;
        end
      end

      S_RUN: begin
        mid_d   = (lo_plus_w > count_q) ? count_q : lo_plus_w;
        hi_d    = (lo_plus_2w > count_q) ? count_q : lo_plus_2w;
        i_d     = lo_q;
        j_d     = (lo_plus_w > count_q) ? count_q : lo_plus_w;
        k_d     = lo_q;
        rd_addr = lo_q[AW-1:0];
        state_d = S_HA;
      end

      S_HA: begin
        head_a_d = rd_data;
        if (j_q < hi_q) begin
          rd_addr = j_q[AW-1:0];
          state_d = S_HB;
        end else begin
          state_d = S_MERGE;
        end
      end

      S_HB: begin
        head_b_d = rd_data;
        state_d  = S_MERGE;
      end

      S_MERGE: begin
        if (!a_ok && !b_ok) begin
          // Run done: advance to the next run or close the pass.
          if (lo_plus_2w >= count_q) begin
            width_d   = width_q << 1;
            src_sel_d = !src_sel_q;
            state_d   = S_PASS;
          end else begin
            lo_d    = lo_plus_2w;
            state_d = S_RUN;
          end
        end else begin
          wr_addr = k_q[AW-1:0];
          wr_data = take_a ? head_a_q : head_b_q;
          elem_we = src_sel_q;
          scr_we  = !src_sel_q;
          k_d     = k_nx;
          if (take_a) begin
            i_d = i_nx;
            if (i_nx < mid_q) begin
              rd_addr = i_nx[AW-1:0];
              state_d = S_WA;
            end
          end else begin
            j_d = j_nx;
            if (j_nx < hi_q) begin
              rd_addr = j_nx[AW-1:0];
              state_d = S_WB;
            end
          end
        end
      end

      S_WA: begin
        head_a_d = rd_data;
        state_d  = S_MERGE;
      end

      S_WB: begin
        head_b_d = rd_data;
        state_d  = S_MERGE;
      end

      S_ERD: begin
        // Hold the read until the output register is free at this edge.
        if (!out_valid_q || !out_stall_i) begin
          rd_addr = k_q[AW-1:0];
          state_d = S_ECAP;
        end
      end

      S_ECAP: begin
        out_valid_d = 1'b1;
        out_value_d = rd_data;
        out_end_d   = last_emit;
        out_ovf_d   = drop_q;
        k_d         = k_nx;
        if (last_emit) begin
          count_d = '0;
          drop_d  = 1'b0;
          state_d = S_LOAD;
        end else begin
          state_d = S_ERD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign end_of_run_o   = out_end_q;
  assign overflow_o     = out_ovf_q;

  `MSB_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= MaxCount, "fill count exceeds capacity")
  `MSB_ASSERT_IMP(a_merge_in_run, clk_i, rst_ni, (state_q == S_MERGE) && (a_ok || b_ok), k_q < hi_q, "merge write beyond run end")
  `MSB_ASSERT_IMP(a_capture_free, clk_i, rst_ni, state_q == S_ECAP, !out_valid_q, "output captured over pending item")
  `MSB_ASSERT_NXT(a_set_closed, clk_i, rst_ni, (state_q == S_ECAP) && last_emit, (state_q == S_LOAD) && (count_q == '0) && !drop_q, "set not cleared after final item")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for merge_sort_buffer_core: drives sets of signed values,
// predicts the sorted stream with its own bottom-up merge and checks every item.
// Depends only on the RTL of merge_sort_buffer_core and msb_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_CAPACITY = 64;
  // Slowest legal run: every item waits out a long input gap, a full-set sort
  // and a long output stall. Take that several times over.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 100;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] value;
    logic               end_of_run;
    logic               overflow;
  } sorted_item_t;

  // Scoreboard: collect the open set, sort it on the closing item and hold
  // the sorted items until the block emits them.
  class sort_scoreboard;
    logic signed [31:0] set_values[$];
    bit                 set_dropped;
    sorted_item_t       pending_sorted[$];
    int                 errors;

    function void mismatch(string what, logic signed [31:0] expv,
                           logic signed [31:0] gotv);
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, what, expv, gotv);
    endfunction

    // Bottom-up merge of the open set; on a tie the right run wins.
    function void sort_and_queue();
      logic signed [31:0] src[SET_CAPACITY];
      logic signed [31:0] dst[SET_CAPACITY];
      sorted_item_t       item;
      int                 n, w, lo, mid, hi, i, j, k;
      n = set_values.size();
      for (k = 0; k < n; k++) src[k] = set_values[k];
      for (w = 1; w < n; w = w * 2) begin
        for (lo = 0; lo < n; lo = lo + 2 * w) begin
          mid = (lo + w < n) ? lo + w : n;
          hi  = (lo + 2 * w < n) ? lo + 2 * w : n;
          i = lo;
          j = mid;
          for (k = lo; k < hi; k++) begin
            if (i < mid && (j >= hi || src[i] < src[j])) begin
              dst[k] = src[i];
              i++;
            end else begin
              dst[k] = src[j];
              j++;
            end
          end
        end
        src = dst;
      end
      for (k = 0; k < n; k++) begin
        item.value      = src[k];
        item.end_of_run = (k == n - 1);
        item.overflow   = set_dropped;
        pending_sorted.insert(pending_sorted.size(), item);
      end
      set_values.delete();
      set_dropped = 0;
    endfunction

    function void take_value(logic signed [31:0] v, logic l);
      if (set_values.size() < SET_CAPACITY) set_values.insert(set_values.size(), v);
      else set_dropped = 1;
      if (l) sort_and_queue();
    endfunction

    function void check_sorted(logic signed [31:0] v, logic eor, logic ovf);
      sorted_item_t exp_item;
      if (pending_sorted.size() == 0) begin
        mismatch("unexpected item, sorted_value", 'x, v);
        return;
      end
      exp_item = pending_sorted.pop_front();
      if (v !== exp_item.value) mismatch("sorted_value", exp_item.value, v);
      if (eor !== exp_item.end_of_run)
        mismatch("end_of_run", exp_item.end_of_run, eor);
      if (ovf !== exp_item.overflow) mismatch("overflow", exp_item.overflow, ovf);
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic signed [31:0] value     = '0;
  logic               last      = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] sorted_value;
  logic               end_of_run;
  logic               overflow;

  sort_scoreboard sb = new();
  bit             quiet = 1'b0;  // set for stretches without any idling
  int             items_sent = 0;
  int             cycles = 0;

  merge_sort_buffer_core #(.MAX_ITEMS(SET_CAPACITY)) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .value_i        (value),
    .last_i         (last),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sorted_value_o (sorted_value),
    .end_of_run_o   (end_of_run),
    .overflow_o     (overflow)
  );

  initial forever #5 clk = ~clk;

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pick_value(int kind);
    if (kind == 3) kind = $urandom_range(0, 2);
    case (kind)
      0: return $urandom;
      // Narrow range: plenty of equal values.
      1: return $signed($urandom_range(0, 15)) - 8;
      default: begin
        case ($urandom_range(0, 5))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 0;
          3: return -1;
          4: return VAL_MIN + 1;
          default: return VAL_MAX - 1;
        endcase
      end
    endcase
  endfunction

  // Output side: stall in runs of random length; start no new run when quiet.
  initial begin : out_stall_gen
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet) hold = pick_gap();
      end
    end
  end

  // Sample results at the rising edge and check them in order.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_sorted(sorted_value, end_of_run, overflow);
  end

  // Offer one item after a random gap; hold it until the block takes it.
  task automatic drive_item(logic signed [31:0] v, logic l);
    int gap;
    gap = quiet ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
      value    <= $urandom;
      last     <= $urandom_range(0, 1);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    value    <= v;
    last     <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_value(v, l);
    items_sent++;
  endtask

  task automatic send_values(logic signed [31:0] vals[$]);
    for (int k = 0; k < vals.size(); k++) drive_item(vals[k], k == vals.size() - 1);
  endtask

  // One set of random content; sizes above capacity exercise the drop path.
  task automatic send_set(int size);
    int kind;
    kind  = $urandom_range(0, 3);
    quiet = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < size; k++) drive_item(pick_value(kind), k == size - 1);
  endtask

  initial begin : stimulus
    logic signed [31:0] vals[$];
    int                 set_idx;
    int                 r;
    int                 size;

    // Hold reset, then release it away from the sampling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: single-item sets at both extremes, extremes with duplicates,
    // all-equal values, already ascending and descending sets.
    vals = '{VAL_MAX};
    send_values(vals);
    vals = '{VAL_MIN};
    send_values(vals);
    vals = '{0, -1, VAL_MAX, VAL_MIN, 1, VAL_MIN, VAL_MAX, 0};
    send_values(vals);
    vals = '{5, 5, 5};
    send_values(vals);
    vals = '{-3, -2, -1, 0, 1, 2};
    send_values(vals);
    vals = '{3, 2, 1, 0, -1};
    send_values(vals);

    // Random sets: mostly small, some full, some overflowing. Open with an
    // overflowing set and an exactly full one so both always appear.
    set_idx = 0;
    while (items_sent < RANDOM_ITEMS + 24) begin
      r = $urandom_range(0, 19);
      if (set_idx == 0 || r == 1) size = $urandom_range(SET_CAPACITY + 1,
                                                        SET_CAPACITY + 6);
      else if (set_idx == 1 || r == 0) size = SET_CAPACITY;
      else if (r < 5) size = $urandom_range(17, SET_CAPACITY - 1);
      else size = $urandom_range(1, 16);
      send_set(size);
      set_idx++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    quiet = 1'b0;

    // Wait for the last sorted item, then watch for strays.
    while (sb.pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending_sorted.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
